// ===== rtl/lvu_pkg.sv =====
// shared types and constants for the langevin velocity update block
`default_nettype none
package lvu_pkg;

  // config register indexes
  localparam int CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] RegVelScale   = 8'd0;
  localparam logic [CfgIdxW-1:0] RegForceScale = 8'd1;
  localparam logic [CfgIdxW-1:0] RegNoiseScale = 8'd2;
  localparam logic [CfgIdxW-1:0] RegStepSize   = 8'd3;

  localparam logic [16:0] VelScaleReset = 17'h10000;

  // cycles from the input register to the result register
  localparam int Lat = 13;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [31:0]        inv_mass;
    logic signed [63:0] force_x;
    logic signed [63:0] force_y;
    logic signed [63:0] force_z;
    logic signed [31:0] noise_x;
    logic signed [31:0] noise_y;
    logic signed [31:0] noise_z;
    logic               last_atom;
  } item_t;

  typedef struct packed {
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
    logic signed [31:0] delta_z;
    logic               moved;
    logic               last_out;
  } result_t;

  typedef struct packed {
    logic [16:0] vel_scale;
    logic [31:0] force_scale;
    logic [31:0] noise_scale;
    logic [31:0] step_size;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/lvu_sqrt.sv =====
// pipelined integer square root, four result bits per stage
`default_nettype none
module lvu_sqrt import lvu_pkg::*; (
  input  wire logic        clk,
  input  wire logic [31:0] inv_mass,
  output logic      [23:0] root
);

  localparam int Stages = 6;
  localparam int Steps  = 4;

  typedef struct packed {
    logic [26:0] rem;
    logic [23:0] root;
    logic [47:0] xs;
  } sq_state_t;

  // one radix-4 digit of the restoring square root
  function automatic sq_state_t sq_step(input sq_state_t s);
    sq_state_t   r;
    logic [26:0] r2;
    logic [26:0] trial;
    r2    = {s.rem[24:0], s.xs[47:46]};
    trial = {1'b0, s.root, 2'b01};
    r.xs  = {s.xs[45:0], 2'b00};
    if (r2 >= trial) begin
      r.rem  = r2 - trial;
      r.root = {s.root[22:0], 1'b1};
    end else begin
      r.rem  = r2;
      r.root = {s.root[22:0], 1'b0};
    end
    return r;
  endfunction

  sq_state_t st0;
  sq_state_t st [Stages];
  sq_state_t st_next [Stages];

  assign st0 = '{rem: '0, root: '0, xs: {inv_mass, 16'h0000}};

  // combinational digits of each stage
  always_comb begin
    st_next[0] = st0;
    for (int k = 1; k < Stages; k++) begin
      st_next[k] = st[k-1];
    end
    for (int k = 0; k < Stages; k++) begin
      for (int j = 0; j < Steps; j++) begin
        st_next[k] = sq_step(st_next[k]);
      end
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < Stages; k++) begin
      st[k] <= st_next[k];
    end
  end

  assign root = st[Stages-1].root;

endmodule
`default_nettype wire

// ===== rtl/lvu_axis.sv =====
// one velocity axis: products, sum, rounding, saturation and delta
`default_nettype none
module lvu_axis import lvu_pkg::*; (
  input  wire logic               clk,
  input  wire cfg_t               cfg,
  input  wire logic signed [31:0] vel,
  input  wire logic signed [63:0] force_in,
  input  wire logic signed [31:0] noise,
  input  wire logic [31:0]        inv_mass,
  input  wire logic [23:0]        sq,
  output logic signed [31:0]      new_vel,
  output logic signed [31:0]      delta
);

  localparam logic [127:0] Half     = 128'h1 << 47;
  localparam logic [127:0] ForceMax = 128'h1 << 110;

  logic [48:0]  m1_1, m1_2, m1_3;
  logic [63:0]  fi_1, mf_1;
  logic         nf_1, nf_2, nf_3;
  logic         nv_1, nv_2, nv_3;
  logic [31:0]  mn_1, mn_2, mn_3, mn_4, mn_5, mn_6, mn_7;
  logic         nn_1, nn_2, nn_3, nn_4, nn_5, nn_6, nn_7, nn_8;
  logic [63:0]  p00, p01, p10, p11;
  logic [127:0] t2u;
  logic [127:0] t1s, t2s;
  logic [127:0] a_5, a_6, a_7, a_8, a_9;
  logic [55:0]  ns;
  logic [63:0]  pl;
  logic [55:0]  ph;
  logic [127:0] t3s;
  logic [127:0] s;
  logic [31:0]  nv_11, nv_12;
  logic [63:0]  pd;
  logic         dneg;
  logic [103:0] t3u;
  logic [64:0]  ps;

  // magnitude of the noise term and the rounded signed step product
  assign t3u = {16'h0000, ({24'h000000, pl} + {ph, 32'h00000000})} << 16;
  assign ps  = (dneg ? (~{1'b0, pd} + 65'd1) : {1'b0, pd}) + 65'h8000;

  always_ff @(posedge clk) begin
    // stage 1: velocity product and force coefficient
    m1_1 <= cfg.vel_scale * (vel[31] ? 32'(-vel) : 32'(vel));
    nv_1 <= vel[31];
    fi_1 <= 64'(cfg.force_scale) * 64'(inv_mass);
    mf_1 <= force_in[63] ? 64'(-force_in) : 64'(force_in);
    nf_1 <= force_in[63];
    mn_1 <= noise[31] ? 32'(-noise) : 32'(noise);
    nn_1 <= noise[31];
    // stage 2: force partial products
    p00  <= 64'(fi_1[31:0])  * 64'(mf_1[31:0]);
    p01  <= 64'(fi_1[31:0])  * 64'(mf_1[63:32]);
    p10  <= 64'(fi_1[63:32]) * 64'(mf_1[31:0]);
    p11  <= 64'(fi_1[63:32]) * 64'(mf_1[63:32]);
    m1_2 <= m1_1;
    nv_2 <= nv_1;
    nf_2 <= nf_1;
    mn_2 <= mn_1;
    nn_2 <= nn_1;
    // stage 3: force product
    t2u  <= {64'h0, p00} + ({64'h0, p01} << 32) + ({64'h0, p10} << 32) + {p11, 64'h0};
    m1_3 <= m1_2;
    nv_3 <= nv_2;
    nf_3 <= nf_2;
    mn_3 <= mn_2;
    nn_3 <= nn_2;
    // stage 4: clamp the force term and apply signs
    if (t2u >= ForceMax) begin
      t2s <= nf_3 ? (~ForceMax + 128'd1) : ForceMax;
    end else begin
      t2s <= nf_3 ? (~t2u + 128'd1) : t2u;
    end
    t1s  <= nv_3 ? (~{47'h0, m1_3, 32'h0} + 128'd1) : {47'h0, m1_3, 32'h0};
    mn_4 <= mn_3;
    nn_4 <= nn_3;
    // stage 5: partial sum with rounding half
    a_5  <= t1s + t2s + Half;
    mn_5 <= mn_4;
    nn_5 <= nn_4;
    // stage 6: wait for the root
    a_6  <= a_5;
    mn_6 <= mn_5;
    nn_6 <= nn_5;
    // stage 7: noise coefficient
    ns   <= 56'(cfg.noise_scale) * 56'(sq);
    a_7  <= a_6;
    mn_7 <= mn_6;
    nn_7 <= nn_6;
    // stage 8: noise partial products
    pl   <= 64'(ns[31:0]) * 64'(mn_7);
    ph   <= 56'(ns[55:32]) * 56'(mn_7);
    a_8  <= a_7;
    nn_8 <= nn_7;
    // stage 9: signed noise term
    t3s  <= nn_8 ? (~{24'h0, t3u} + 128'd1) : {24'h0, t3u};
    a_9  <= a_8;
    // stage 10: full sum
    s    <= a_9 + t3s;
    // stage 11: round and saturate the velocity
    if (s[127:79] == '0 || s[127:79] == '1) begin
      nv_11 <= s[79:48];
    end else begin
      nv_11 <= s[127] ? 32'h80000000 : 32'h7fffffff;
    end
    // stage 12: step product
    pd    <= 64'(nv_11[31] ? 32'(-nv_11) : nv_11) * 64'(cfg.step_size);
    dneg  <= nv_11[31];
    nv_12 <= nv_11;
    // stage 13: round and saturate the delta
    if (ps[64:47] == '0 || ps[64:47] == '1) begin
      delta <= ps[47:16];
    end else begin
      delta <= ps[64] ? 32'h80000000 : 32'h7fffffff;
    end
    new_vel <= nv_12;
  end

endmodule
`default_nettype wire

// ===== rtl/langevin_velocity_update.sv =====
// top level of the langevin velocity update pipeline
//
// One atom enters per clock: an item is taken on start while busy is low,
// and busy stays low, so items may follow each other in every cycle.
// Each item's result appears on result after the input register and the
// pipeline stages, for one cycle with done high, and is accepted at the edge
// after that; the receiver cannot stall it and the pipeline never holds.
// Throughput is one item per cycle; latency is set by the six-stage square
// root and the multiplier stages that follow it.
// Configuration goes over cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Index 0 vel_scale, 1 force_scale, 2 noise_scale,
// 3 step_size; other indexes are ignored. Write only while no item is in
// flight.
// Reset clears all items in flight and loads vel_scale with 1.0 and the
// other registers with zero.
// An atom with zero inverse mass returns its velocity with zero deltas and
// moved low.
`default_nettype none
module langevin_velocity_update import lvu_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire item_t              item,
  output logic                    done,
  output result_t                 result,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [31:0]        cfg_data
);

  cfg_t  cfg;
  item_t in_q;
  logic  vld [Lat+1];
  logic  fix_d [Lat+1];
  logic  last_d [Lat+1];
  logic [31:0] vx_d [Lat+1];
  logic [31:0] vy_d [Lat+1];
  logic [31:0] vz_d [Lat+1];
  logic [23:0] sq;
  logic signed [31:0] nvx, nvy, nvz, dx, dy, dz;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{vel_scale: VelScaleReset, force_scale: '0, noise_scale: '0, step_size: '0};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegVelScale:   cfg.vel_scale   <= cfg_data[16:0];
        RegForceScale: cfg.force_scale <= cfg_data;
        RegNoiseScale: cfg.noise_scale <= cfg_data;
        RegStepSize:   cfg.step_size   <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= Lat; k++) vld[k] <= 1'b0;
    end else begin
      vld[0] <= start && !busy;
      for (int k = 1; k <= Lat; k++) vld[k] <= vld[k-1];
    end
  end

  // input register and side-band delay line
  always_ff @(posedge clk) begin
    in_q      <= item;
    fix_d[0]  <= item.inv_mass == 32'h0;
    last_d[0] <= item.last_atom;
    vx_d[0]   <= item.vel_x;
    vy_d[0]   <= item.vel_y;
    vz_d[0]   <= item.vel_z;
    for (int k = 1; k <= Lat; k++) begin
      fix_d[k]  <= fix_d[k-1];
      last_d[k] <= last_d[k-1];
      vx_d[k]   <= vx_d[k-1];
      vy_d[k]   <= vy_d[k-1];
      vz_d[k]   <= vz_d[k-1];
    end
  end

  lvu_sqrt u_sqrt (.clk(clk), .inv_mass(in_q.inv_mass), .root(sq));

  lvu_axis u_ax (.clk(clk), .cfg(cfg), .vel(in_q.vel_x), .force_in(in_q.force_x),
    .noise(in_q.noise_x), .inv_mass(in_q.inv_mass), .sq(sq), .new_vel(nvx), .delta(dx));
  lvu_axis u_ay (.clk(clk), .cfg(cfg), .vel(in_q.vel_y), .force_in(in_q.force_y),
    .noise(in_q.noise_y), .inv_mass(in_q.inv_mass), .sq(sq), .new_vel(nvy), .delta(dy));
  lvu_axis u_az (.clk(clk), .cfg(cfg), .vel(in_q.vel_z), .force_in(in_q.force_z),
    .noise(in_q.noise_z), .inv_mass(in_q.inv_mass), .sq(sq), .new_vel(nvz), .delta(dz));

  // fixed atoms pass through
  always_comb begin
    done            = vld[Lat];
    result.moved    = !fix_d[Lat];
    result.last_out = last_d[Lat];
    if (fix_d[Lat]) begin
      result.new_vel_x = vx_d[Lat];
      result.new_vel_y = vy_d[Lat];
      result.new_vel_z = vz_d[Lat];
      result.delta_x   = '0;
      result.delta_y   = '0;
      result.delta_z   = '0;
    end else begin
      result.new_vel_x = nvx;
      result.new_vel_y = nvy;
      result.new_vel_z = nvz;
      result.delta_x   = dx;
      result.delta_y   = dy;
      result.delta_z   = dz;
    end
  end

  // a result only follows an accepted item
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, Lat+1))
    else $error("result without an item");

  // moved flag follows the item's inverse mass
  a_moved: assert property (@(posedge clk) disable iff (rst)
    done |-> result.moved == $past(item.inv_mass != 32'h0, Lat+1))
    else $error("moved flag mismatch");

  // batch marker travels with its item
  a_last: assert property (@(posedge clk) disable iff (rst)
    done |-> result.last_out == $past(item.last_atom, Lat+1))
    else $error("last marker mismatch");

endmodule
`default_nettype wire
